// ===== design/oamd_pkg.sv =====
// types, codes and helpers shared by the operand address mode decoder
package oamd_pkg;

  localparam int RegCount = 8;
  localparam int RegAddrW = 3;
  localparam int WordW    = 16;

  localparam logic [1:0] OP_DECODE = 2'd0;
  localparam logic [1:0] OP_FETCH  = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_ADDR  = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;
  localparam logic [1:0] KIND_RVAL  = 2'd3;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DEFER    = 2'd1;
  localparam logic [1:0] PH_INDEX    = 2'd2;
  localparam logic [1:0] PH_INDEXDEF = 2'd3;

  localparam logic [2:0] MODE_REG      = 3'd0;
  localparam logic [2:0] MODE_REGDEF   = 3'd1;
  localparam logic [2:0] MODE_AUTOINC  = 3'd2;
  localparam logic [2:0] MODE_AINCDEF  = 3'd3;
  localparam logic [2:0] MODE_AUTODEC  = 3'd4;
  localparam logic [2:0] MODE_ADECDEF  = 3'd5;
  localparam logic [2:0] MODE_INDEX    = 3'd6;
  localparam logic [2:0] MODE_INDEXDEF = 3'd7;

  localparam logic [RegAddrW-1:0] REG_SP = 3'd6;
  localparam logic [RegAddrW-1:0] REG_PC = 3'd7;

  localparam logic [WordW-1:0] WORD_STEP = 16'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [2:0]       mode;
    logic [2:0]       reg_number;
    logic [WordW-1:0] opcode;
    logic [WordW-1:0] data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [WordW-1:0] value;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [WordW-1:0]    data;
  } rf_wr_t;

  function automatic logic byte_opcode(input logic [WordW-1:0] oc);
    return oc inside {[16'o1050:16'o1067], [16'o11:16'o15]};
  endfunction

  function automatic logic [WordW-1:0] step_size(input logic [WordW-1:0] oc,
                                                 input logic [RegAddrW-1:0] r);
    logic one;
    one = byte_opcode(oc) && (r != REG_SP) && (r != REG_PC);
    return one ? 16'd1 : WORD_STEP;
  endfunction

endpackage

// ===== design/oamd_regfile.sv =====
// general register file, one read port and one write port
module oamd_regfile
  import oamd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [RegAddrW-1:0] rd_addr,
  output logic [WordW-1:0]    rd_data,
  input  rf_wr_t              wr
);

  logic [WordW-1:0] regs_r [RegCount];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RegCount; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr.en) begin
      regs_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = regs_r[rd_addr];

endmodule

// ===== design/oamd_exec.sv =====
// addressing mode decode, register update and pending fetch tracking
module oamd_exec
  import oamd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  in_item_t            item,
  output logic [RegAddrW-1:0] rd_addr,
  input  logic [WordW-1:0]    rd_data,
  output rf_wr_t              wr,
  output logic                res_valid,
  output out_item_t           res
);

  logic [1:0]          phase_r, phase_nxt;
  logic [RegAddrW-1:0] preg_r, preg_nxt;
  logic [WordW-1:0]    step;
  logic [WordW-1:0]    idx_sum;

  assign step    = step_size(item.opcode, item.reg_number);
  assign idx_sum = rd_data + item.data;

  always_comb begin
    if (item.op == OP_FETCH) begin
      rd_addr = preg_r;
    end else if (item.op == OP_DECODE &&
                 (item.mode == MODE_INDEX || item.mode == MODE_INDEXDEF)) begin
      rd_addr = REG_PC;
    end else begin
      rd_addr = item.reg_number;
    end
  end

  always_comb begin
    wr        = '{en: 1'b0, addr: item.reg_number, data: item.data};
    res_valid = 1'b0;
    res       = '{kind: KIND_REG, value: rd_data};
    phase_nxt = phase_r;
    preg_nxt  = preg_r;
    case (item.op)
      OP_WRITE: begin
        wr.en = 1'b1;
      end
      OP_READ: begin
        res_valid = 1'b1;
        res.kind  = KIND_RVAL;
      end
      OP_FETCH: begin
        case (phase_r)
          PH_DEFER: begin
            res_valid = 1'b1;
            res       = '{kind: KIND_ADDR, value: item.data};
            phase_nxt = PH_IDLE;
          end
          PH_INDEX: begin
            res_valid = 1'b1;
            res       = '{kind: KIND_ADDR, value: idx_sum};
            phase_nxt = PH_IDLE;
          end
          PH_INDEXDEF: begin
            res_valid = 1'b1;
            res       = '{kind: KIND_FETCH, value: idx_sum};
            phase_nxt = PH_DEFER;
          end
          default: begin
          end
        endcase
      end
      default: begin
        res_valid = 1'b1;
        phase_nxt = PH_IDLE;
        case (item.mode)
          MODE_REG: begin
            res = '{kind: KIND_REG, value: {{(WordW-RegAddrW){1'b0}}, item.reg_number}};
          end
          MODE_REGDEF: begin
            res.kind = KIND_ADDR;
          end
          MODE_AUTOINC: begin
            res.kind = KIND_ADDR;
            wr       = '{en: 1'b1, addr: item.reg_number, data: rd_data + step};
          end
          MODE_AINCDEF: begin
            res.kind  = KIND_FETCH;
            wr        = '{en: 1'b1, addr: item.reg_number, data: rd_data + WORD_STEP};
            phase_nxt = PH_DEFER;
          end
          MODE_AUTODEC: begin
            wr  = '{en: 1'b1, addr: item.reg_number, data: rd_data - step};
            res = '{kind: KIND_ADDR, value: rd_data - step};
          end
          MODE_ADECDEF: begin
            wr        = '{en: 1'b1, addr: item.reg_number, data: rd_data - WORD_STEP};
            res       = '{kind: KIND_FETCH, value: rd_data - WORD_STEP};
            phase_nxt = PH_DEFER;
          end
          default: begin
            res.kind  = KIND_FETCH;
            wr        = '{en: 1'b1, addr: REG_PC, data: rd_data + WORD_STEP};
            preg_nxt  = item.reg_number;
            phase_nxt = (item.mode == MODE_INDEX) ? PH_INDEX : PH_INDEXDEF;
          end
        endcase
      end
    endcase
    if (!fire) begin
      wr.en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      preg_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      preg_r  <= preg_nxt;
    end
  end

endmodule

// ===== design/operand_address_mode_decoder_unit.sv =====
// top level: input register, decode with register file, output register
//
//  channel | ports                          | carries
//  --------+--------------------------------+---------------------------------
//  in      | in_valid, in_stall, in_item    | decode, fetched word, reg write/read
//  out     | out_valid, out_stall, out_item | register, address, fetch, reg value
//
// one item per cycle unless out stalls; results pass the in and out registers
// each item: at most one register read, one add and one write, in the same cycle
// synchronous active-low reset clears registers, pending fetch and valid flags
// a stalled out holds its item; in stalls only while out is stalled and full
module operand_address_mode_decoder_unit
  import oamd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic                in_valid_r;
  in_item_t            in_item_r;
  logic                out_valid_r;
  out_item_t           out_item_r;
  logic                adv;
  logic                accept;
  logic [RegAddrW-1:0] rd_addr;
  logic [WordW-1:0]    rd_data;
  rf_wr_t              wr;
  logic                res_valid;
  out_item_t           res;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_item;
    end
  end

  oamd_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  oamd_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (adv),
    .item      (in_item_r),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (wr),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== design/oamd_checker.sv =====
// port-level checks for the operand address mode decoder, with bind
module oamd_checker
  import oamd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out item dropped while stalled");

  a_out_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("out item changed while stalled");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in stalled without a stalled full output");

  a_reg_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.op == OP_DECODE && in_item.mode == MODE_REG)
      ##1 (!out_valid || !out_stall)
      |=> out_valid && out_item.kind == KIND_REG &&
          out_item.value[2:0] == $past(in_item.reg_number, 2))
    else $error("register mode item not reported as register operand");

  a_reg_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_item.op == OP_READ)
      ##1 (!out_valid || !out_stall)
      |=> out_valid && out_item.kind == KIND_RVAL)
    else $error("register read item gave no register value");

endmodule

bind operand_address_mode_decoder_unit oamd_checker u_oamd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== tb/sv/operand_address_mode_decoder_unit_chk.sv =====
`timescale 1ns / 1ps
// operand decoder checker: tracks register file and pending fetch, compares every result item
module operand_address_mode_decoder_unit_chk
  import oamd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        error_count,
  output int        waiting_count
);

  localparam logic [WordW-1:0] BYTE_EXT_LO = 16'o1050;
  localparam logic [WordW-1:0] BYTE_EXT_HI = 16'o1067;
  localparam logic [WordW-1:0] BYTE_BAS_LO = 16'o11;
  localparam logic [WordW-1:0] BYTE_BAS_HI = 16'o15;

  logic [WordW-1:0]    gpr [RegCount];
  logic [1:0]          fetch_phase;
  logic [RegAddrW-1:0] index_reg;
  out_item_t           operand_q [$];

  function automatic out_item_t result_of(input logic [1:0] k, input logic [WordW-1:0] v);
    out_item_t x;
    x.kind  = k;
    x.value = v;
    return x;
  endfunction

  task automatic flag(input string what, input out_item_t want, input out_item_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t %s: expected kind %0d value %h, got kind %0d value %h",
               $realtime, what, want.kind, want.value, got.kind, got.value);
    end
  endtask

  task automatic resolve_operand(input in_item_t it);
    logic [WordW-1:0] addr;
    logic [WordW-1:0] incr;
    logic             byte_op;
    byte_op = (it.opcode >= BYTE_EXT_LO && it.opcode <= BYTE_EXT_HI) ||
              (it.opcode >= BYTE_BAS_LO && it.opcode <= BYTE_BAS_HI);
    incr = (byte_op && it.reg_number != REG_SP && it.reg_number != REG_PC) ? 16'd1 : WORD_STEP;
    case (it.op)
      OP_WRITE: begin
        gpr[it.reg_number] = it.data;
      end
      OP_READ: begin
        operand_q.push_back(result_of(KIND_RVAL, gpr[it.reg_number]));
      end
      OP_FETCH: begin
        case (fetch_phase)
          PH_DEFER: begin
            fetch_phase = PH_IDLE;
            operand_q.push_back(result_of(KIND_ADDR, it.data));
          end
          PH_INDEX: begin
            fetch_phase = PH_IDLE;
            operand_q.push_back(result_of(KIND_ADDR, gpr[index_reg] + it.data));
          end
          PH_INDEXDEF: begin
            fetch_phase = PH_DEFER;
            operand_q.push_back(result_of(KIND_FETCH, gpr[index_reg] + it.data));
          end
          default: ;
        endcase
      end
      default: begin
        fetch_phase = PH_IDLE;
        case (it.mode)
          MODE_REG: begin
            operand_q.push_back(result_of(KIND_REG, {13'd0, it.reg_number}));
          end
          MODE_REGDEF: begin
            operand_q.push_back(result_of(KIND_ADDR, gpr[it.reg_number]));
          end
          MODE_AUTOINC: begin
            addr = gpr[it.reg_number];
            gpr[it.reg_number] = addr + incr;
            operand_q.push_back(result_of(KIND_ADDR, addr));
          end
          MODE_AINCDEF: begin
            addr = gpr[it.reg_number];
            gpr[it.reg_number] = addr + WORD_STEP;
            fetch_phase = PH_DEFER;
            operand_q.push_back(result_of(KIND_FETCH, addr));
          end
          MODE_AUTODEC: begin
            gpr[it.reg_number] = gpr[it.reg_number] - incr;
            operand_q.push_back(result_of(KIND_ADDR, gpr[it.reg_number]));
          end
          MODE_ADECDEF: begin
            gpr[it.reg_number] = gpr[it.reg_number] - WORD_STEP;
            fetch_phase = PH_DEFER;
            operand_q.push_back(result_of(KIND_FETCH, gpr[it.reg_number]));
          end
          default: begin
            addr = gpr[REG_PC];
            gpr[REG_PC] = addr + WORD_STEP;
            index_reg = it.reg_number;
            fetch_phase = (it.mode == MODE_INDEX) ? PH_INDEX : PH_INDEXDEF;
            operand_q.push_back(result_of(KIND_FETCH, addr));
          end
        endcase
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < RegCount; i++) gpr[i] = '0;
      fetch_phase = PH_IDLE;
      index_reg = '0;
      operand_q.delete();
      error_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (operand_q.size() == 0) begin
          flag("unexpected item", result_of(KIND_REG, '0), out_item);
        end else begin
          want = operand_q.pop_front();
          if (want.kind !== out_item.kind || want.value !== out_item.value) begin
            flag("mismatch", want, out_item);
          end
        end
      end
      if (in_valid && !in_stall) resolve_operand(in_item);
    end
    waiting_count = operand_q.size();
  end

endmodule

// ===== tb/sv/operand_address_mode_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, operand specifier stimulus, stalls, watchdog and verdict
module operand_address_mode_decoder_unit_tb;
  import oamd_pkg::*;

  localparam int ItemTarget = 1250;
  localparam int StuckLimit = 5000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_pkt;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_pkt;
  int        error_count;
  int        waiting_count;
  bit        quiet;
  int        stuck_cycles = 0;

  operand_address_mode_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_pkt),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_pkt)
  );

  operand_address_mode_decoder_unit_chk chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_pkt),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_pkt),
    .error_count   (error_count),
    .waiting_count (waiting_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 1) ? 16'hFFFE : 16'h0001;
      3: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // byte opcode ranges, their neighbors and random opcodes
  function automatic logic [WordW-1:0] pick_opcode();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(16'o1050, 16'o1067));
      1: return 16'($urandom_range(16'o11, 16'o15));
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'o1047;
          1: return 16'o1070;
          2: return 16'o10;
          default: return 16'o16;
        endcase
      end
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_item_t mk(input logic [1:0] op, input logic [2:0] mode,
                                  input logic [2:0] r, input logic [WordW-1:0] oc,
                                  input logic [WordW-1:0] data);
    in_item_t x;
    x.op = op;
    x.mode = mode;
    x.reg_number = r;
    x.opcode = oc;
    x.data = data;
    return x;
  endfunction

  function automatic in_item_t rnd_item(input logic [1:0] op);
    return mk(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pick_opcode(),
              pick_word());
  endfunction

  task automatic send(input in_item_t it);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_pkt <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin : out_side
    int  run;
    bit  hold;
    run = 0;
    hold = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        hold = !quiet && ($urandom_range(0, 2) == 0);
        run = hold ? idle_len() + 1 : $urandom_range(1, 8);
      end
      out_stall <= hold;
      run--;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    int         sent;
    int         extras;
    logic [2:0] mode;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pkt = '0;
    quiet = 1'b0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(mk(OP_READ, MODE_REG, 3'd3, 16'h0000, 16'h0000));
    send(mk(OP_WRITE, MODE_REG, 3'd0, 16'h0000, 16'hFFFF));
    send(mk(OP_WRITE, MODE_REG, REG_SP, 16'hFFFF, 16'h0001));
    send(mk(OP_WRITE, MODE_REG, REG_PC, 16'h0000, 16'h1000));
    send(mk(OP_WRITE, MODE_REG, 3'd1, 16'h0000, 16'h8000));
    send(mk(OP_DECODE, MODE_REG, 3'd5, 16'hFFFF, 16'hFFFF));
    send(mk(OP_DECODE, MODE_REGDEF, 3'd0, 16'h0000, 16'h0000));
    send(mk(OP_DECODE, MODE_AUTOINC, 3'd0, 16'o1050, 16'h0000));
    send(mk(OP_DECODE, MODE_AUTOINC, REG_SP, 16'o15, 16'h0000));
    send(mk(OP_DECODE, MODE_AUTODEC, 3'd1, 16'o1067, 16'h0000));
    send(mk(OP_DECODE, MODE_AUTODEC, 3'd2, 16'o1070, 16'h0000));
    send(mk(OP_DECODE, MODE_AINCDEF, REG_PC, 16'o11, 16'h0000));
    send(mk(OP_FETCH, MODE_REG, 3'd0, 16'h0000, 16'hFFFF));
    send(mk(OP_DECODE, MODE_ADECDEF, 3'd0, 16'o11, 16'h0000));
    send(mk(OP_FETCH, MODE_REG, 3'd0, 16'h0000, 16'h0000));
    send(mk(OP_DECODE, MODE_INDEX, 3'd1, 16'h0000, 16'h0000));
    send(mk(OP_FETCH, MODE_REG, 3'd0, 16'h0000, 16'hFFFF));
    send(mk(OP_DECODE, MODE_INDEXDEF, REG_PC, 16'h0000, 16'h0000));
    send(mk(OP_FETCH, MODE_REG, 3'd0, 16'h0000, 16'h7FFE));
    send(mk(OP_FETCH, MODE_REG, 3'd0, 16'h0000, 16'h1234));
    // fetched word with nothing pending
    send(mk(OP_FETCH, MODE_REG, 3'd0, 16'h0000, 16'hABCD));
    // register access while an index fetch is pending
    send(mk(OP_DECODE, MODE_INDEX, 3'd2, 16'h0000, 16'h0000));
    send(mk(OP_WRITE, MODE_REG, 3'd2, 16'h0000, 16'hF000));
    send(mk(OP_READ, MODE_REG, 3'd2, 16'h0000, 16'h0000));
    send(mk(OP_FETCH, MODE_REG, 3'd0, 16'h0000, 16'h2000));
    // new decode abandons a pending fetch
    send(mk(OP_DECODE, MODE_INDEXDEF, 3'd3, 16'h0000, 16'h0000));
    send(mk(OP_DECODE, MODE_AINCDEF, 3'd4, 16'h0000, 16'h0000));
    send(mk(OP_FETCH, MODE_REG, 3'd0, 16'h0000, 16'h0F0F));

    while (sent < ItemTarget) begin
      if ($urandom_range(0, 149) == 0) quiet = !quiet;
      case ($urandom_range(0, 99)) inside
        [0:59]: begin
          mode = 3'($urandom_range(0, 7));
          send(mk(OP_DECODE, mode, 3'($urandom_range(0, 7)), pick_opcode(), pick_word()));
          sent++;
          extras = (mode == MODE_INDEXDEF) ? 2 :
                   (mode == MODE_AINCDEF || mode == MODE_ADECDEF || mode == MODE_INDEX) ? 1 : 0;
          if ($urandom_range(0, 9) == 0) extras = $urandom_range(0, extras);
          repeat (extras) begin
            if ($urandom_range(0, 5) == 0) begin
              send(rnd_item($urandom_range(0, 1) ? OP_WRITE : OP_READ));
              sent++;
            end
            send(rnd_item(OP_FETCH));
            sent++;
          end
        end
        [60:79]: begin
          send(rnd_item(OP_WRITE));
          sent++;
        end
        [80:91]: begin
          send(rnd_item(OP_READ));
          sent++;
        end
        default: begin
          send(rnd_item(OP_FETCH));
          sent++;
        end
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (error_count == 0 && waiting_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== operand_address_mode_decoder_unit.f =====
design/oamd_pkg.sv
design/oamd_regfile.sv
design/oamd_exec.sv
design/operand_address_mode_decoder_unit.sv
design/oamd_checker.sv
tb/sv/operand_address_mode_decoder_unit_chk.sv
tb/sv/operand_address_mode_decoder_unit_tb.sv
